>>> rtl/core/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the checked integer ALU
// Operation and status codes, the queued command record and widths.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned OpWidth   = 5;
  localparam int unsigned CntWidth  = $clog2(DataWidth + 1);

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SHL = 5'd8, OP_SHR = 5'd9,
    OP_EQ = 5'd10, OP_NE = 5'd11, OP_LT = 5'd12, OP_LE = 5'd13, OP_GT = 5'd14,
    OP_GE = 5'd15, OP_IMP = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2, ST_SHIFT = 2'd3
  } status_e;

  // Command classes decided by the front end.
  typedef enum logic [1:0] {
    K_DONE = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 is_mod;
    logic                 sgn;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    status_e              st;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MUL_CHK, S_DIV, S_DIV_FIX, S_OUT
  } state_e;

endpackage

>>> rtl/core/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front: input stage
// Accepts items, finishes the operations that need no multiplier or divider and classifies the rest.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpWidth-1:0]   op_i,
  input  logic                 sgn_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  localparam logic [DataWidth-1:0] SignBit = {1'b1, {(DataWidth-1){1'b0}}};

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic [DataWidth:0]   sum, dif;
  logic [DataWidth-1:0] r, shv, shr_fill;
  logic lt_s, lt_u, lt, gt, eq, big_sh;
  logic [$clog2(DataWidth)-1:0] sh;

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    sum  = {1'b0, a_i} + {1'b0, b_i};
    dif  = {1'b0, a_i} - {1'b0, b_i};
    eq   = (a_i == b_i);
    lt_u = dif[DataWidth];
    lt_s = (a_i[DataWidth-1] != b_i[DataWidth-1]) ? a_i[DataWidth-1] : lt_u;
    lt   = sgn_i ? lt_s : lt_u;
    gt   = !lt && !eq;
    big_sh = (b_i >= DataWidth'(DataWidth));
    sh   = b_i[$clog2(DataWidth)-1:0];
    shr_fill = (sgn_i && a_i[DataWidth-1]) ? ~((~a_i) >> sh) : (a_i >> sh);
    shv  = a_i << sh;
    cmd_d = '{kind: K_DONE, is_mod: 1'b0, sgn: sgn_i, a: a_i, b: b_i, st: ST_OK};
    r = '0;
    case (op_i)
      OP_ADD: begin
        r = sum[DataWidth-1:0];
        if (sgn_i ? (!(a_i[DataWidth-1] ^ b_i[DataWidth-1]) &&
                     (a_i[DataWidth-1] ^ r[DataWidth-1])) : sum[DataWidth])
          cmd_d.st = ST_OVF;
      end
      OP_SUB: begin
        r = dif[DataWidth-1:0];
        if (sgn_i ? ((a_i[DataWidth-1] ^ b_i[DataWidth-1]) &&
                     (a_i[DataWidth-1] ^ r[DataWidth-1])) : dif[DataWidth])
          cmd_d.st = ST_OVF;
      end
      OP_MUL: cmd_d.kind = K_MUL;
      OP_DIV, OP_MOD: begin
        cmd_d.is_mod = (op_i == OP_MOD);
        if (b_i == '0) cmd_d.st = ST_DIV0;
        else if (sgn_i && a_i == SignBit && b_i == '1) cmd_d.st = ST_OVF;
        else cmd_d.kind = K_DIV;
      end
      OP_AND: r = a_i & b_i;
      OP_OR:  r = a_i | b_i;
      OP_XOR: r = a_i ^ b_i;
      OP_SHL: if (big_sh) cmd_d.st = ST_SHIFT; else r = shv;
      OP_SHR: if (big_sh) cmd_d.st = ST_SHIFT; else r = shr_fill;
      OP_EQ:  r = {{(DataWidth-1){1'b0}}, eq};
      OP_NE:  r = {{(DataWidth-1){1'b0}}, !eq};
      OP_LT:  r = {{(DataWidth-1){1'b0}}, lt};
      OP_LE:  r = {{(DataWidth-1){1'b0}}, lt || eq};
      OP_GT:  r = {{(DataWidth-1){1'b0}}, gt};
      OP_GE:  r = {{(DataWidth-1){1'b0}}, !lt};
      OP_IMP: r = (a_i == '0) ? {{(DataWidth-1){1'b0}}, 1'b1} : b_i;
      default: r = '0;
    endcase
    if (cmd_d.st != ST_OK) r = '0;
    cmd_d.a = (cmd_d.kind == K_DONE) ? r : a_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/core/cia_queue.sv
// ----------------------------------------------------------------------------
// cia_queue: command queue
// Small FIFO between the front end and the execution unit.
// ----------------------------------------------------------------------------
module cia_queue import cia_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> rtl/core/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back: execution unit
// Multiplies with four 32x32 partial products, divides one bit a cycle.
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [DataWidth-1:0] value_o,
  output logic [1:0]           status_o
);

  localparam int unsigned H = DataWidth / 2;

  state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q;
  cmd_t c_q;
  logic xn_q, yn_q;
  logic [DataWidth-1:0] ua_q, ub_q, quo_q, rem_q;
  logic [2*DataWidth-1:0] acc_q;
  logic [DataWidth-1:0] val_q;
  status_e st_q;
  logic [DataWidth+1:0] trial;
  logic [DataWidth:0] rem_sh;
  logic [DataWidth-1:0] pa, pb, res_mag, pp_raw;
  logic [2*DataWidth-1:0] prod_s, pp;
  logic [H-1:0] ma, mb;
  logic mul_ovf, take;

  assign take        = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == S_IDLE) || (state_q == S_OUT && res_ready_i);
  assign res_valid_o = (state_q == S_OUT);
  assign value_o     = val_q;
  assign status_o    = st_q;

  always_comb begin
    // one 32x32 partial product a cycle, cnt selects halves
    ma = cnt_q[0] ? ua_q[DataWidth-1:H] : ua_q[H-1:0];
    mb = cnt_q[1] ? ub_q[DataWidth-1:H] : ub_q[H-1:0];
    pp_raw = ma * mb;
    pp = {{DataWidth{1'b0}}, pp_raw} << (H * (cnt_q[0] + cnt_q[1]));
    // remainder keeps its top bit while shifting
    rem_sh = {rem_q, quo_q[DataWidth-1]};
    trial  = {1'b0, rem_sh} - {2'b00, ub_q};
    prod_s = (xn_q ^ yn_q) ? (~acc_q + 1'b1) : acc_q;
    if (c_q.sgn)
      mul_ovf = (prod_s[2*DataWidth-1:DataWidth-1] != '0) &&
                (prod_s[2*DataWidth-1:DataWidth-1] != '1);
    else
      mul_ovf = (acc_q[2*DataWidth-1:DataWidth] != '0);
    res_mag = c_q.is_mod ? rem_q : quo_q;
    pa = (cmd_i.sgn && cmd_i.a[DataWidth-1]) ? -cmd_i.a : cmd_i.a;
    pb = (cmd_i.sgn && cmd_i.b[DataWidth-1]) ? -cmd_i.b : cmd_i.b;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && res_ready_i) state_d = S_IDLE;
        if (take) begin
          case (cmd_i.kind)
            K_MUL:   state_d = S_MUL;
            K_DIV:   state_d = S_DIV;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_MUL:     if (cnt_q == CntWidth'(3)) state_d = S_MUL_CHK;
      S_MUL_CHK: state_d = S_OUT;
      S_DIV:     if (cnt_q == CntWidth'(DataWidth - 1)) state_d = S_DIV_FIX;
      S_DIV_FIX: state_d = S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_MUL: begin
        acc_q <= acc_q + pp;
        cnt_q <= cnt_q + 1'b1;
      end
      S_MUL_CHK: begin
        val_q <= mul_ovf ? '0 : prod_s[DataWidth-1:0];
        st_q  <= mul_ovf ? ST_OVF : ST_OK;
      end
      S_DIV: begin
        quo_q <= {quo_q[DataWidth-2:0], !trial[DataWidth+1]};
        rem_q <= trial[DataWidth+1] ? rem_sh[DataWidth-1:0] : trial[DataWidth-1:0];
        cnt_q <= cnt_q + 1'b1;
      end
      S_DIV_FIX: begin
        st_q <= ST_OK;
        if (c_q.is_mod) val_q <= xn_q ? -res_mag : res_mag;
        else val_q <= (xn_q ^ yn_q) ? -res_mag : res_mag;
      end
      default: ;
    endcase
    if (take) begin
      c_q   <= cmd_i;
      cnt_q <= '0;
      xn_q  <= cmd_i.sgn && cmd_i.a[DataWidth-1];
      yn_q  <= cmd_i.sgn && cmd_i.b[DataWidth-1];
      ua_q  <= pa;
      ub_q  <= pb;
      quo_q <= pa;
      rem_q <= '0;
      acc_q <= '0;
      val_q <= cmd_i.a;
      st_q  <= cmd_i.st;
    end
  end

endmodule

>>> rtl/core/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu: overflow-checked 64-bit integer ALU
// Front end, command queue and multi-cycle execution unit.
// ----------------------------------------------------------------------------
// Operations without multiplier or divider (add, sub, logic, shifts, compares,
// implies) are finished in the front end and pass its register, the queue and
// the result register of the execution unit; a new request is taken every
// cycle while results are consumed. Multiply uses four 32x32 partial products
// on one multiplier, divide and modulo a restoring divider (one quotient bit
// per cycle). The execution unit handles one request at a time; the front end
// and a two-entry queue keep accepting while it works, until both are full.
// Any nonzero status forces the value to zero.
module checked_integer_alu import cia_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // operation[4:0], signed_mode[5],
                                      // operand_a[69:6], operand_b[133:70]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // value[63:0], status[65:64]
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;
  logic [DataWidth-1:0] value;
  logic [1:0] status;

  cia_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[4:0]),
    .sgn_i      (s_axis_tdata[5]),
    .a_i        (s_axis_tdata[69:6]),
    .b_i        (s_axis_tdata[133:70]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  cia_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  cia_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .value_o(value), .status_o(status)
  );

  assign m_axis_tdata = {6'b0, status, value};

endmodule
